>>> hw/rtl/tkft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkft_pkg
// Shared types and constants for the top-k fame tracker.
// ----------------------------------------------------------------------------
package tkft_pkg;

	localparam int UID_W  = 32;
	localparam int DEG_W  = 24;
	localparam int FAME_W = DEG_W + 1;
	localparam int RANK_W = 6;

	localparam logic KIND_OFFER   = 1'b0;
	localparam logic KIND_READOUT = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic              load_offer;
		logic              load_read;
		logic [RANK_W-1:0] read_idx;
	} cmd_t;

	function automatic logic signed [FAME_W-1:0] fame(input logic [DEG_W-1:0] indeg,
		input logic [DEG_W-1:0] outdeg);
		fame = $signed({1'b0, indeg}) - $signed({1'b0, outdeg});
	endfunction

endpackage

>>> hw/rtl/tkft_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkft_ctrl
// Sequencer: takes offers, walks the list on readout, owns the output valid.
// ----------------------------------------------------------------------------
module tkft_ctrl #(
	parameter int LIST_SIZE = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic          s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic          m_tlast,
	output tkft_pkg::cmd_t cmd
);

	localparam int IDX_W = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LIST_SIZE - 1);

	tkft_pkg::state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             vld_q, vld_d;
	logic             last_q, last_d;
	logic             out_free;

	assign out_free = !vld_q || m_tready;
	assign m_tvalid = vld_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tkft_pkg::ST_IDLE;
			idx_q   <= '0;
			vld_q   <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			vld_q   <= vld_d;
			last_q  <= last_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		idx_d          = idx_q;
		vld_d          = vld_q;
		last_d         = last_q;
		s_tready       = 1'b0;
		cmd.load_offer = 1'b0;
		cmd.load_read  = 1'b0;
		cmd.read_idx   = tkft_pkg::RANK_W'(idx_q);
		if (out_free) begin
			vld_d = 1'b0;
		end
		case (state_q)
			tkft_pkg::ST_IDLE: begin
				s_tready = out_free;
				if (s_tvalid && out_free) begin
					if (s_tuser == tkft_pkg::KIND_READOUT) begin
						state_d = tkft_pkg::ST_READ;
						idx_d   = '0;
					end else begin
						cmd.load_offer = 1'b1;
						vld_d          = 1'b1;
						last_d         = 1'b1;
					end
				end
			end
			tkft_pkg::ST_READ: begin
				if (out_free) begin
					cmd.load_read = 1'b1;
					vld_d         = 1'b1;
					last_d        = (idx_q == IDX_LAST);
					idx_d         = idx_q + 1'b1;
					if (idx_q == IDX_LAST) begin
						state_d = tkft_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = tkft_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/tkft_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkft_datapath
// Row of list slots with per-slot fame compare, insertion shift and
// readout rotation, plus the output payload register.
// ----------------------------------------------------------------------------
module tkft_datapath #(
	parameter int LIST_SIZE = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tkft_pkg::cmd_t                cmd,
	input  logic [tkft_pkg::UID_W-1:0]    uid,
	input  logic [tkft_pkg::DEG_W-1:0]    in_degree,
	input  logic [tkft_pkg::DEG_W-1:0]    out_degree,
	output logic                          accepted,
	output logic [tkft_pkg::RANK_W-1:0]   rank,
	output logic [tkft_pkg::UID_W-1:0]    entry_uid,
	output logic [tkft_pkg::DEG_W-1:0]    entry_in_degree,
	output logic [tkft_pkg::DEG_W-1:0]    entry_out_degree
);

	logic [tkft_pkg::UID_W-1:0] uid_q  [LIST_SIZE];
	logic [tkft_pkg::DEG_W-1:0] ind_q  [LIST_SIZE];
	logic [tkft_pkg::DEG_W-1:0] outd_q [LIST_SIZE];

	logic signed [tkft_pkg::FAME_W-1:0] new_fame;
	logic [LIST_SIZE-1:0] ge;
	logic [LIST_SIZE-1:0] ins;
	logic                 take;
	logic [tkft_pkg::RANK_W-1:0] pos;

	assign new_fame = tkft_pkg::fame(in_degree, out_degree);

	// list is sorted, so ge over kept slots is a run of ones then zeros
	always_comb begin
		for (int i = 0; i < LIST_SIZE; i++) begin
			ge[i] = (tkft_pkg::fame(ind_q[i], outd_q[i]) >= new_fame);
		end
		take = !ge[LIST_SIZE-1];
		for (int i = 0; i < LIST_SIZE; i++) begin
			if (i == LIST_SIZE - 1) begin
				ins[i] = (i == 0) ? 1'b1 : ge[(i == 0) ? 0 : i-1];
			end else begin
				ins[i] = !ge[i] && ((i == 0) ? 1'b1 : ge[(i == 0) ? 0 : i-1]);
			end
		end
		pos = '0;
		for (int i = 0; i < LIST_SIZE; i++) begin
			if (ins[i]) begin
				pos = pos | tkft_pkg::RANK_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LIST_SIZE; i++) begin
				uid_q[i]  <= '0;
				ind_q[i]  <= '0;
				outd_q[i] <= '0;
			end
		end else if (cmd.load_offer && take) begin
			for (int i = 0; i < LIST_SIZE; i++) begin
				if (ins[i]) begin
					uid_q[i]  <= uid;
					ind_q[i]  <= in_degree;
					outd_q[i] <= out_degree;
				end else if (i > 0 && !ge[(i == 0) ? 0 : i-1]) begin
					uid_q[i]  <= uid_q[(i == 0) ? 0 : i-1];
					ind_q[i]  <= ind_q[(i == 0) ? 0 : i-1];
					outd_q[i] <= outd_q[(i == 0) ? 0 : i-1];
				end
			end
		end else if (cmd.load_read) begin
			// rotate toward slot 0; after a full readout the list is back in place
			for (int i = 0; i < LIST_SIZE; i++) begin
				uid_q[i]  <= uid_q[(i + 1) % LIST_SIZE];
				ind_q[i]  <= ind_q[(i + 1) % LIST_SIZE];
				outd_q[i] <= outd_q[(i + 1) % LIST_SIZE];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_offer) begin
			accepted         <= take;
			rank             <= take ? pos : '0;
			entry_uid        <= '0;
			entry_in_degree  <= '0;
			entry_out_degree <= '0;
		end else if (cmd.load_read) begin
			accepted         <= 1'b0;
			rank             <= cmd.read_idx;
			entry_uid        <= uid_q[0];
			entry_in_degree  <= ind_q[0];
			entry_out_degree <= outd_q[0];
		end
	end

endmodule

>>> hw/rtl/top_k_fame_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_fame_tracker_core
// Keeps the LIST_SIZE entries of highest fame (in-degree minus out-degree)
// in sorted order; offers insert, readouts stream the whole list.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                                 | side
//  s_axis  | in  | uid[31:0] in_degree[55:32] out_degree[79:56]        | tuser = kind
//  m_axis  | out | accepted[0] rank[6:1] entry_uid[38:7]                | tlast = last
//          |     | entry_in_degree[62:39] entry_out_degree[86:63] 0[87] |
//
// an offer's result shows the cycle after it is taken; offers can follow
// back to back, limited by the single output register
// a readout gives LIST_SIZE results, one slot per cycle unless m_axis stalls,
// as the slot row rotates past slot 0; after its transfer the controller
// enters ST_READ, which loads each slot into the output register and takes
// no input transfer; reset clears all slots at once; a stalled m_axis holds
// the result and stops input only until the output register frees up
module top_k_fame_tracker_core #(
	parameter int LIST_SIZE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // uid, in_degree, out_degree
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // accepted, rank, entry_uid, entry_in_degree,
	                               // entry_out_degree, zero pad
	output logic        m_tlast    // last
);

	tkft_pkg::cmd_t cmd;

	logic                          accepted;
	logic [tkft_pkg::RANK_W-1:0]   rank;
	logic [tkft_pkg::UID_W-1:0]    entry_uid;
	logic [tkft_pkg::DEG_W-1:0]    entry_in_degree;
	logic [tkft_pkg::DEG_W-1:0]    entry_out_degree;

	tkft_ctrl #(
		.LIST_SIZE(LIST_SIZE)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tlast  (m_tlast),
		.cmd      (cmd)
	);

	tkft_datapath #(
		.LIST_SIZE(LIST_SIZE)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.uid              (s_tdata[31:0]),
		.in_degree        (s_tdata[55:32]),
		.out_degree       (s_tdata[79:56]),
		.accepted         (accepted),
		.rank             (rank),
		.entry_uid        (entry_uid),
		.entry_in_degree  (entry_in_degree),
		.entry_out_degree (entry_out_degree)
	);

	assign m_tdata = {1'b0, entry_out_degree, entry_in_degree, entry_uid, rank, accepted};

endmodule
